>>> src/rbf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the replay buffer frontend
package rbf_pkg;

  // default parameter values
  localparam int REPLAY_SLOTS_DEF = 32;
  localparam int OPCODE_SHIFT_DEF = 24;

  // depth of the command queue between front and back (power of two)
  localparam int CMD_QUEUE_DEPTH = 4;

  // replay word layout
  localparam int FIELD_W   = 10;
  localparam int LEN_LSB   = 4;
  localparam int START_LSB = 14;
  localparam int LOAD_BIT  = 0;
  localparam int EXEC_BIT  = 1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRACE_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NOP_OPCODE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLAY_OPCODE = 2'd2;

  // configuration reset values
  localparam logic [31:0] TRACE_LIMIT_RST   = 32'd65536;
  localparam logic [7:0]  NOP_OPCODE_RST    = 8'h02;
  localparam logic [7:0]  REPLAY_OPCODE_RST = 8'h04;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_LIMIT = 2'd2;

  // command kinds
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_EMIT  = 2'd0;
  localparam cmd_kind_t CMD_RUN   = 2'd1;
  localparam cmd_kind_t CMD_ERROR = 2'd2;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic [31:0] trace_limit;
    logic [7:0]  nop_opcode;
    logic [7:0]  replay_opcode;
  } cfg_t;

  // replay word fields
  function automatic logic [FIELD_W-1:0] replay_len(input logic [31:0] w);
    return w[LEN_LSB +: FIELD_W];
  endfunction

  function automatic logic [FIELD_W-1:0] replay_start(input logic [31:0] w);
    return w[START_LSB +: FIELD_W];
  endfunction

endpackage

>>> src/rbf_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port
module rbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/rbf_cmd_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front and back parts
module rbf_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  rbf_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rbf_pkg::cmd_t pop_cmd
);

  import rbf_pkg::*;

  localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_QUEUE_DEPTH);

  cmd_t             entries [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and fill level (depth is a power of two, pointers wrap)
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> src/rbf_front.sv
`timescale 1ns / 1ps
// Front part: accepts instruction words, captures into the buffer, queues commands
module rbf_front #(
  parameter int REPLAY_SLOTS = rbf_pkg::REPLAY_SLOTS_DEF,
  parameter int OPCODE_SHIFT = rbf_pkg::OPCODE_SHIFT_DEF,
  localparam int ADDR_W = (REPLAY_SLOTS > 1) ? $clog2(REPLAY_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  rbf_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       instr_word,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output rbf_pkg::cmd_t     cmd,
  input  logic              run_done,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [31:0]       ram_wdata
);

  import rbf_pkg::*;

  localparam int CNT_W  = $clog2(REPLAY_SLOTS + 1);
  localparam int PEND_W = $clog2(CMD_QUEUE_DEPTH + 2);
  localparam int WIDE_W = FIELD_W + 1;
  localparam logic [WIDE_W-1:0] SLOTS_WIDE = WIDE_W'(REPLAY_SLOTS);
  localparam logic [CNT_W-1:0]  SLOTS_CNT  = CNT_W'(REPLAY_SLOTS);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(REPLAY_SLOTS - 1);

  logic              clearing;
  logic [ADDR_W-1:0] clear_addr;
  logic [CNT_W-1:0]  cap_slot;
  logic [CNT_W-1:0]  cap_rem;
  logic              cap_echo;
  logic [PEND_W-1:0] run_pend;

  logic               accept;
  logic               capturing;
  logic               is_replay;
  logic [FIELD_W-1:0] f_len;
  logic [FIELD_W-1:0] f_start;
  logic [WIDE_W-1:0]  f_end;
  logic               range_bad;
  logic               run_push;

  // decode of the incoming word
  assign capturing = (cap_rem != '0);
  assign is_replay = ((instr_word >> OPCODE_SHIFT) == {24'd0, cfg.replay_opcode});
  assign f_len     = replay_len(instr_word);
  assign f_start   = replay_start(instr_word);
  assign f_end     = {1'b0, f_start} + {1'b0, f_len};
  assign range_bad = ({1'b0, f_start} >= SLOTS_WIDE) || ({1'b0, f_len} > SLOTS_WIDE) ||
                     (f_end > SLOTS_WIDE);

  // captures wait while a replay run that may read the buffer is outstanding
  assign in_ready = !clearing && cmd_ready && !(capturing && run_pend != '0);
  assign accept   = in_valid && in_ready;

  // command to the back part
  always_comb begin
    cmd_valid = 1'b0;
    cmd.kind  = CMD_EMIT;
    cmd.word  = instr_word;
    if (accept) begin
      if (capturing) begin
        cmd_valid = cap_echo;
      end else if (is_replay) begin
        if (range_bad) begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_ERROR;
        end else if (!instr_word[LOAD_BIT] && f_len != '0) begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_RUN;
        end
      end else begin
        cmd_valid = 1'b1;
      end
    end
  end

  assign run_push = cmd_valid && (cmd.kind == CMD_RUN);

  // buffer write port: clearing pass, then captured words
  assign ram_we    = clearing || (accept && capturing && cap_slot < SLOTS_CNT);
  assign ram_waddr = clearing ? clear_addr : cap_slot[ADDR_W-1:0];
  assign ram_wdata = clearing ? 32'd0 : instr_word;

  // capture window and clearing state
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
      cap_slot   <= '0;
      cap_rem    <= '0;
      cap_echo   <= 1'b0;
    end else begin
      if (clearing) begin
        if (clear_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end else begin
          clear_addr <= clear_addr + 1'b1;
        end
      end
      if (accept) begin
        if (capturing) begin
          cap_slot <= cap_slot + 1'b1;
          cap_rem  <= cap_rem - 1'b1;
        end else if (is_replay && !range_bad && instr_word[LOAD_BIT]) begin
          cap_slot <= f_start[CNT_W-1:0];
          cap_rem  <= f_len[CNT_W-1:0];
          cap_echo <= instr_word[EXEC_BIT];
        end
      end
    end
  end

  // replay runs queued or in progress in the back part
  always_ff @(posedge clk) begin
    if (rst) begin
      run_pend <= '0;
    end else if (run_push && !run_done) begin
      run_pend <= run_pend + 1'b1;
    end else if (run_done && !run_push) begin
      run_pend <= run_pend - 1'b1;
    end
  end

endmodule

>>> src/rbf_back.sv
`timescale 1ns / 1ps
// Back part: carries out commands, replays buffer ranges, enforces the trace limit
module rbf_back #(
  parameter int REPLAY_SLOTS = rbf_pkg::REPLAY_SLOTS_DEF,
  parameter int OPCODE_SHIFT = rbf_pkg::OPCODE_SHIFT_DEF,
  localparam int ADDR_W = (REPLAY_SLOTS > 1) ? $clog2(REPLAY_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  rbf_pkg::cfg_t     cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  rbf_pkg::cmd_t     cmd,
  output logic              run_done,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [31:0]       ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_word,
  output logic [1:0]        status,
  output logic              last
);

  import rbf_pkg::*;

  localparam int WIDE_W = FIELD_W + 1;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_RUN   = 2'd1;
  localparam logic [1:0] B_FLUSH = 2'd2;

  logic [1:0]        state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] last_idx, last_idx_next;
  logic              failed, failed_next;
  logic [31:0]       count, count_next;
  logic              p_valid, p_valid_next;
  logic [31:0]       p_word, p_word_next;
  logic [1:0]        p_status, p_status_next;
  logic              out_valid_next;
  logic [31:0]       out_word_next;
  logic [1:0]        status_next;
  logic              last_next;

  logic               o_free;
  logic               over;
  logic               h_nop;
  logic               r_nop;
  logic               can_step;
  logic [FIELD_W-1:0] h_start;
  logic [WIDE_W-1:0]  h_end_idx;

  function automatic logic is_nop(input logic [31:0] w, input logic [7:0] op);
    return (w >> OPCODE_SHIFT) == {24'd0, op};
  endfunction

  assign o_free    = !out_valid || out_ready;
  assign over      = (count >= cfg.trace_limit);
  assign h_nop     = is_nop(cmd.word, cfg.nop_opcode);
  assign r_nop     = is_nop(ram_rdata, cfg.nop_opcode);
  assign h_start   = replay_start(cmd.word);
  assign h_end_idx = {1'b0, h_start} + {1'b0, replay_len(cmd.word)} - 1'b1;
  assign can_step  = r_nop || !p_valid || o_free;

  // command sequencer; a replay run keeps one result held back so that the
  // last marker lands on the final result of the run
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    last_idx_next  = last_idx;
    failed_next    = failed;
    count_next     = count;
    p_valid_next   = p_valid;
    p_word_next    = p_word;
    p_status_next  = p_status;
    out_valid_next = out_valid && !out_ready;
    out_word_next  = out_word;
    status_next    = status;
    last_next      = last;
    cmd_ready      = 1'b0;
    run_done       = 1'b0;
    ram_raddr      = idx;
    case (state)
      B_IDLE: begin
        ram_raddr = h_start[ADDR_W-1:0];
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_RUN: begin
              cmd_ready = 1'b1;
              if (failed) begin
                run_done = 1'b1;
              end else begin
                state_next    = B_RUN;
                idx_next      = h_start[ADDR_W-1:0];
                last_idx_next = h_end_idx[ADDR_W-1:0];
              end
            end
            CMD_EMIT: begin
              if (o_free) begin
                cmd_ready = 1'b1;
                if (!failed && !h_nop) begin
                  out_valid_next = 1'b1;
                  last_next      = 1'b1;
                  if (over) begin
                    failed_next   = 1'b1;
                    out_word_next = 32'd0;
                    status_next   = STATUS_LIMIT;
                  end else begin
                    count_next    = count + 1'b1;
                    out_word_next = cmd.word;
                    status_next   = STATUS_OK;
                  end
                end
              end
            end
            CMD_ERROR: begin
              if (o_free) begin
                cmd_ready = 1'b1;
                if (!failed) begin
                  failed_next    = 1'b1;
                  out_valid_next = 1'b1;
                  out_word_next  = 32'd0;
                  status_next    = STATUS_RANGE;
                  last_next      = 1'b1;
                end
              end
            end
            default: begin
              cmd_ready = 1'b1;
            end
          endcase
        end
      end
      B_RUN: begin
        if (can_step) begin
          if (!r_nop) begin
            // pass the held result on, it is not the last one
            if (p_valid) begin
              out_valid_next = 1'b1;
              out_word_next  = p_word;
              status_next    = p_status;
              last_next      = 1'b0;
            end
            p_valid_next = 1'b1;
            if (over) begin
              failed_next   = 1'b1;
              p_word_next   = 32'd0;
              p_status_next = STATUS_LIMIT;
            end else begin
              count_next    = count + 1'b1;
              p_word_next   = ram_rdata;
              p_status_next = STATUS_OK;
            end
          end
          if (!r_nop && over) begin
            state_next = B_FLUSH;
          end else if (idx == last_idx) begin
            state_next = B_FLUSH;
          end else begin
            idx_next  = idx + 1'b1;
            ram_raddr = idx + 1'b1;
          end
        end
      end
      B_FLUSH: begin
        if (!p_valid) begin
          state_next = B_IDLE;
          run_done   = 1'b1;
        end else if (o_free) begin
          out_valid_next = 1'b1;
          out_word_next  = p_word;
          status_next    = p_status;
          last_next      = 1'b1;
          p_valid_next   = 1'b0;
          state_next     = B_IDLE;
          run_done       = 1'b1;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      failed    <= 1'b0;
      count     <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      failed    <= failed_next;
      count     <= count_next;
      p_valid   <= p_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // run indexes and result payload
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    last_idx <= last_idx_next;
    p_word   <= p_word_next;
    p_status <= p_status_next;
    out_word <= out_word_next;
    status   <= status_next;
    last     <= last_next;
  end

endmodule

>>> src/replay_buffer_frontend_unit.sv
`timescale 1ns / 1ps
// Top level of the replay buffer frontend: configuration registers and part wiring
//
// Instruction words enter on the input channel and results leave on the output channel.
// A plain word, or a word inside an execute-while-loading capture window, passes at one
// transfer per cycle through the front part, the command queue and the back part while the
// back part is idle and the output side takes results. In the back part a replay run of n
// buffer words takes the command, reads one buffer word per cycle while the output side
// takes results, and releases its final result. The queue keeps taking words meanwhile,
// but a capture word waits until every outstanding run has finished reading the buffer.
// Results leave through an output register at one per cycle while the output side
// takes them. After reset the buffer is cleared slot by slot, during which no input is
// taken; configuration writes are taken at any time, one per cycle.
module replay_buffer_frontend_unit #(
  parameter int REPLAY_SLOTS = rbf_pkg::REPLAY_SLOTS_DEF,
  parameter int OPCODE_SHIFT = rbf_pkg::OPCODE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     instr_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_word,
  output logic [1:0]                      status,
  output logic                            last
);

  import rbf_pkg::*;

  localparam int ADDR_W = (REPLAY_SLOTS > 1) ? $clog2(REPLAY_SLOTS) : 1;

  cfg_t              cfg;
  logic              f_cmd_valid;
  logic              f_cmd_ready;
  cmd_t              f_cmd;
  logic              b_cmd_valid;
  logic              b_cmd_ready;
  cmd_t              b_cmd;
  logic              run_done;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trace_limit   <= TRACE_LIMIT_RST;
      cfg.nop_opcode    <= NOP_OPCODE_RST;
      cfg.replay_opcode <= REPLAY_OPCODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRACE_LIMIT:   cfg.trace_limit   <= cfg_data;
        CFG_NOP_OPCODE:    cfg.nop_opcode    <= cfg_data[7:0];
        CFG_REPLAY_OPCODE: cfg.replay_opcode <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front part
  rbf_front #(
    .REPLAY_SLOTS (REPLAY_SLOTS),
    .OPCODE_SHIFT (OPCODE_SHIFT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .instr_word (instr_word),
    .cmd_valid  (f_cmd_valid),
    .cmd_ready  (f_cmd_ready),
    .cmd        (f_cmd),
    .run_done   (run_done),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  // command queue
  rbf_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_cmd_valid),
    .push_ready (f_cmd_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_cmd_valid),
    .pop_ready  (b_cmd_ready),
    .pop_cmd    (b_cmd)
  );

  // replay buffer
  rbf_ram #(
    .WIDTH (32),
    .DEPTH (REPLAY_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back part
  rbf_back #(
    .REPLAY_SLOTS (REPLAY_SLOTS),
    .OPCODE_SHIFT (OPCODE_SHIFT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (b_cmd_valid),
    .cmd_ready (b_cmd_ready),
    .cmd       (b_cmd),
    .run_done  (run_done),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .status    (status),
    .last      (last)
  );

endmodule

>>> tb/tb_replay_buffer_frontend_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the replay buffer frontend: random and directed word streams against a shadow model
module tb_replay_buffer_frontend_unit;
  import rbf_pkg::*;

  localparam int SLOTS       = REPLAY_SLOTS_DEF;
  localparam int OPC_SHIFT   = OPCODE_SHIFT_DEF;
  localparam int LAT_PAUSE   = 2 * SLOTS + 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_PCT    = 28;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_FROM   = 150;
  localparam int CALM_TO     = 230;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  st;
    logic        last;
  } trace_result_t;

  typedef enum logic {ENDS_IN_RANGE_ERROR, ENDS_IN_TRACE_LIMIT} ending_t;

  // dut signals
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            instr_word = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [31:0]            out_word;
  logic [1:0]             status;
  logic                   last;

  // shadow copy of the block state and registers
  logic [31:0] shadow_store [SLOTS];
  int          cap_slot;
  int          cap_left;
  logic        cap_echo;
  logic        blk_failed;
  logic [31:0] trace_count;
  logic [31:0] trace_limit_reg;
  logic [7:0]  nop_op;
  logic [7:0]  replay_op;

  // stimulus and expected trace
  logic [31:0]   word_queue [$];
  trace_result_t trace_due [$];
  trace_result_t due_head;
  int            words_in = 0;
  int            results_checked = 0;
  int            replayed_words = 0;
  int            mismatches = 0;
  int            hold_left = 0;
  logic          hold_done = 1'b0;
  int            timeout_cycles = 0;
  ending_t       ending;

  replay_buffer_frontend_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .instr_word (instr_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .status     (status),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow model
  function automatic void push_due(input logic [31:0] w, input logic [1:0] st);
    trace_result_t r;
    r.word = w;
    r.st   = st;
    r.last = 1'b0;
    trace_due.push_back(r);
  endfunction

  // one emit towards the trace, subject to nop drop and trace limit
  function automatic void trace_word(input logic [31:0] w);
    if (!blk_failed && w[31:OPC_SHIFT] != nop_op) begin
      if (trace_count >= trace_limit_reg) begin
        blk_failed = 1'b1;
        push_due(32'd0, STATUS_LIMIT);
      end else begin
        trace_count = trace_count + 32'd1;
        push_due(w, STATUS_OK);
      end
    end
  endfunction

  function automatic void decode_word(input logic [31:0] w);
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] start;
    int                 due_before;
    int                 i;
    trace_result_t      tail;
    due_before = trace_due.size();
    len   = w[LEN_LSB +: FIELD_W];
    start = w[START_LSB +: FIELD_W];
    if (!blk_failed) begin
      if (cap_left > 0) begin
        // capture window: stored without decoding
        if (cap_slot < SLOTS) shadow_store[cap_slot] = w;
        cap_slot++;
        cap_left--;
        if (cap_echo) trace_word(w);
      end else if (w[31:OPC_SHIFT] == replay_op) begin
        if (int'(start) >= SLOTS || int'(len) > SLOTS || int'(start) + int'(len) > SLOTS) begin
          blk_failed = 1'b1;
          push_due(32'd0, STATUS_RANGE);
        end else if (w[LOAD_BIT]) begin
          cap_slot = int'(start);
          cap_left = int'(len);
          cap_echo = w[EXEC_BIT];
        end else begin
          for (i = 0; i < int'(len) && !blk_failed; i++) begin
            trace_word(shadow_store[int'(start) + i]);
            replayed_words++;
          end
        end
      end else begin
        trace_word(w);
      end
    end
    // mark the final result of this word
    if (trace_due.size() > due_before) begin
      tail = trace_due.pop_back();
      tail.last = 1'b1;
      trace_due.push_back(tail);
    end
  endfunction

  // stimulus helpers
  function automatic logic [31:0] rword(input logic [7:0] op, input int start, input int len,
                                        input logic [3:0] low);
    return {op, 10'(start), 10'(len), low};
  endfunction

  function automatic logic [31:0] plain_word();
    logic [31:0] w;
    w = $urandom;
    if (w[31:OPC_SHIFT] == replay_op) w[31:OPC_SHIFT] = replay_op ^ 8'h01;
    return w;
  endfunction

  // mostly short ranges, now and then the whole space left
  function automatic int pick_len(input int room);
    if ($urandom_range(0, 9) == 0) return room;
    return $urandom_range(0, (room < 6) ? room : 6);
  endfunction

  function automatic void queue_random_mix(input int n);
    int          added;
    int          kind;
    int          start;
    int          len;
    int          k;
    logic [31:0] w;
    added = 0;
    while (added < n) begin
      kind  = $urandom_range(0, 99);
      start = $urandom_range(0, SLOTS - 1);
      len   = pick_len(SLOTS - start);
      if (kind < 30) begin
        word_queue.push_back(plain_word());
        added++;
      end else if (kind < 40 && nop_op != replay_op) begin
        w = $urandom;
        w[31:OPC_SHIFT] = nop_op;
        word_queue.push_back(w);
        added++;
      end else if (kind < 65) begin
        // capture window followed by its payload, replay-looking words included
        word_queue.push_back(rword(replay_op, start, len, {2'($urandom), 1'($urandom), 1'b1}));
        added++;
        for (k = 0; k < len; k++) begin
          w = $urandom;
          if ($urandom_range(0, 4) == 0) w[31:OPC_SHIFT] = replay_op;
          word_queue.push_back(w);
          added++;
        end
      end else begin
        word_queue.push_back(rword(replay_op, start, len, {3'($urandom), 1'b0}));
        added++;
      end
    end
  endfunction

  // register write, applied to the shadow at the transfer
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TRACE_LIMIT:   trace_limit_reg = data;
      CFG_NOP_OPCODE:    nop_op = data[7:0];
      CFG_REPLAY_OPCODE: replay_op = data[7:0];
      default: ;
    endcase
  endtask

  // wait for every word to go in and every result to come out, then let the block settle
  task automatic settle();
    do @(negedge clk); while (word_queue.size() != 0 || in_valid || trace_due.size() != 0);
    repeat (LAT_PAUSE) @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_word(instr_word);
        words_in <= words_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (word_queue.size() != 0 &&
            ((words_in >= CALM_FROM && words_in < CALM_TO) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          instr_word <= word_queue.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side readiness, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (words_in >= CALM_FROM && words_in < CALM_TO) ||
                   ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // result checks
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (trace_due.size() == 0) begin
        $error("unexpected result: out_word %h status %0d last %0d", out_word, status, last);
        mismatches++;
      end else begin
        due_head = trace_due.pop_front();
        if (out_word !== due_head.word) begin
          $error("out_word: expected %h, got %h", due_head.word, out_word);
          mismatches++;
        end
        if (status !== due_head.st) begin
          $error("status: expected %0d, got %0d", due_head.st, status);
          mismatches++;
        end
        if (last !== due_head.last) begin
          $error("last: expected %0d, got %0d", due_head.last, last);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  // watchdog
  initial begin
    while (timeout_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      timeout_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin
    int          k;
    int          form;
    logic [31:0] w;
    for (k = 0; k < SLOTS; k++) shadow_store[k] = 32'd0;
    cap_slot        = 0;
    cap_left        = 0;
    cap_echo        = 1'b0;
    blk_failed      = 1'b0;
    trace_count     = 32'd0;
    trace_limit_reg = TRACE_LIMIT_RST;
    nop_op          = NOP_OPCODE_RST;
    replay_op       = REPLAY_OPCODE_RST;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // unmapped register index, must change nothing
    write_reg(CFG_UNUSED, $urandom);

    // directed words under reset settings
    word_queue.push_back(32'h0000_0000);
    word_queue.push_back(32'hFFFF_FFFF);
    word_queue.push_back({nop_op, 24'h00_1234});
    word_queue.push_back(rword(replay_op, 0, 0, 4'b0000));
    word_queue.push_back(rword(replay_op, 5, 0, 4'b0011));
    word_queue.push_back(rword(replay_op, 0, 4, 4'b0001));
    word_queue.push_back(32'h1111_1111);
    word_queue.push_back(rword(replay_op, 40, 40, 4'b0000));
    word_queue.push_back({nop_op, 24'hAB_CDEF});
    word_queue.push_back(32'hA5A5_5A5A);
    word_queue.push_back(rword(replay_op, 0, 4, 4'b1100));
    word_queue.push_back(rword(replay_op, 28, 4, 4'b0011));
    word_queue.push_back(32'h0102_0304);
    word_queue.push_back({nop_op, 24'h00_0000});
    word_queue.push_back(32'h7FFF_FFFF);
    word_queue.push_back(32'h8000_0000);
    word_queue.push_back(rword(replay_op, 0, SLOTS, 4'b0000));
    word_queue.push_back(rword(replay_op, SLOTS - 1, 1, 4'b0010));
    word_queue.push_back(rword(replay_op, 3, SLOTS - 3, 4'b0000));
    word_queue.push_back(32'hDEAD_BEEF);
    settle();

    // extreme opcodes, widest trace limit
    write_reg(CFG_TRACE_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_NOP_OPCODE, 32'h0000_0000);
    write_reg(CFG_REPLAY_OPCODE, 32'h0000_00FF);
    queue_random_mix(95);
    settle();

    write_reg(CFG_NOP_OPCODE, 32'h0000_00FF);
    write_reg(CFG_REPLAY_OPCODE, 32'h0000_0000);
    write_reg(CFG_TRACE_LIMIT, 32'h0010_0000 + $urandom_range(0, 32'h0010_0000));
    queue_random_mix(95);
    settle();

    // random opcodes, now and then nop and replay the same
    w = $urandom_range(0, 255);
    write_reg(CFG_NOP_OPCODE, w);
    if ($urandom_range(0, 3) != 0) w = $urandom_range(0, 255);
    write_reg(CFG_REPLAY_OPCODE, w);
    queue_random_mix(85);
    settle();

    // closing failure, one kind per run since the block stays failed
    ending = ending_t'($urandom_range(0, 1));
    if (ending == ENDS_IN_TRACE_LIMIT) begin
      // fill the whole buffer with words none of which is a nop
      word_queue.push_back(rword(replay_op, 0, SLOTS, 4'b0001));
      for (k = 0; k < SLOTS; k++) begin
        w = $urandom;
        if (w[31:OPC_SHIFT] == nop_op) w[31:OPC_SHIFT] = nop_op ^ 8'h80;
        word_queue.push_back(w);
      end
      settle();
      write_reg(CFG_TRACE_LIMIT, trace_count + $urandom_range(0, SLOTS - 1));
      word_queue.push_back(rword(replay_op, 0, SLOTS, 4'b0000));
    end else begin
      form = $urandom_range(0, 2);
      if (form == 0)       // start past the buffer
        word_queue.push_back(rword(replay_op, $urandom_range(SLOTS, 1023),
                                   $urandom_range(0, 1023), 4'($urandom)));
      else if (form == 1)  // length past the buffer
        word_queue.push_back(rword(replay_op, $urandom_range(0, SLOTS - 1),
                                   $urandom_range(SLOTS + 1, 1023), 4'($urandom)));
      else begin           // range running off the end
        k = $urandom_range(1, SLOTS - 1);
        word_queue.push_back(rword(replay_op, k, $urandom_range(SLOTS - k + 1, SLOTS),
                                   4'($urandom)));
      end
    end
    // failed block stays silent
    for (k = 0; k < 6; k++) word_queue.push_back(plain_word());
    word_queue.push_back(rword(replay_op, 0, 8, 4'b0000));
    settle();

    write_reg(CFG_TRACE_LIMIT, 32'd1);
    for (k = 0; k < 4; k++) word_queue.push_back(plain_word());
    settle();

    $display("covered %0d words in, %0d results checked, %0d buffer words replayed",
             words_in, results_checked, replayed_words);
    $display("closing failure: %s", (ending == ENDS_IN_TRACE_LIMIT) ? "trace limit" : "range");
    if (mismatches == 0 && trace_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
